/* design/fdrf_pkg.sv */
// Package for the FNV-1a duplicate request filter.
// Holds the hash constants, item function codes, shared types and the FNV step function.
// No dependencies.
package fdrf_pkg;

  localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
  localparam logic [63:0] WINDOW_RESET = 64'd200000000;

  // Bytes hashed per command or argument section before it closes.
  localparam logic [7:0] SECTION_MAX_BYTES = 8'd128;

  localparam int RING_ENTRIES_DEF = 16;

  localparam logic [2:0] FUNC_SUBMITTER = 3'd0;
  localparam logic [2:0] FUNC_TYPE      = 3'd1;
  localparam logic [2:0] FUNC_COMMAND   = 3'd2;
  localparam logic [2:0] FUNC_ARGUMENT  = 3'd3;
  localparam logic [2:0] FUNC_FINISH    = 3'd4;
  localparam logic [2:0] NO_SECTION     = 3'd7;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  data_byte;
    logic [63:0] now_ticks;
  } item_t;

  typedef struct packed {
    logic       fire;
    logic [2:0] func;
    logic [7:0] data_byte;
  } hash_ctl_t;

  // One FNV-1a step: (h ^ b) * 0x00000100000001B3, as shifts and adds.
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

/* design/fnv_duplicate_request_filter_core.sv */
// Top level of the FNV-1a duplicate request filter.
// Depends on fdrf_pkg, fdrf_hash and fdrf_ring.
//
// Usage:
//   Input channel (in_valid/in_ready, func, data_byte, now_ticks) streams a
//   request one item per transfer: submitter byte, type byte, command and
//   argument bytes, then a finish item with the current timestamp.
//   Output channel (out_valid/out_ready, duplicate, fingerprint,
//   slot_written) carries one result per finish item; byte items and unused
//   codes give no result.
//   A finish item's result passes through the input register, then the
//   result register. Throughput: one item per cycle while no finish item
//   waits on a stalled result, set by the single hash step and the parallel
//   compare over all ring entries between the two registers.
//   When the receiver stalls, the held result stays; byte items keep flowing,
//   and one more finish item may wait in the input register before in_ready
//   drops.
//   Reset (rst, synchronous) empties the ring, returns the hash to the offset
//   basis and loads window_ticks with 200000000. cfg_wen/cfg_wdata write
//   window_ticks; the user writes only while the block is idle (unenforced).
module fnv_duplicate_request_filter_core #(
  parameter int RING_ENTRIES = fdrf_pkg::RING_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [7:0]  data_byte,
  input  logic [63:0] now_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        duplicate,
  output logic [63:0] fingerprint,
  output logic [3:0]  slot_written
);
  import fdrf_pkg::*;

  localparam int HEAD_W = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;

  logic [63:0]       window_ticks;
  item_t             in_q;
  logic              in_q_valid;
  logic              proc_fire;
  logic              fin_fire;
  hash_ctl_t         hctl;
  logic [63:0]       hash;
  logic              ring_dup;
  logic [HEAD_W-1:0] ring_head;

  // A finish item advances only when the result register is free or being
  // drained; byte items never wait.
  assign proc_fire = in_q_valid &&
                     ((in_q.func != FUNC_FINISH) || !out_valid || out_ready);
  assign fin_fire  = proc_fire && (in_q.func == FUNC_FINISH);
  assign in_ready  = !in_q_valid || proc_fire;

  // Hold the window register; write only on the config strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= WINDOW_RESET;
    end else if (cfg_wen) begin
      window_ticks <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (proc_fire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q.func      <= func;
      in_q.data_byte <= data_byte;
      in_q.now_ticks <= now_ticks;
    end
  end

  assign hctl.fire      = proc_fire;
  assign hctl.func      = in_q.func;
  assign hctl.data_byte = in_q.data_byte;

  fdrf_hash u_hash (
    .clk  (clk),
    .rst  (rst),
    .ctl  (hctl),
    .hash (hash)
  );

  fdrf_ring #(
    .RING_ENTRIES (RING_ENTRIES)
  ) u_ring (
    .clk          (clk),
    .rst          (rst),
    .rec_fire     (fin_fire),
    .fp           (hash),
    .now_ticks    (in_q.now_ticks),
    .window_ticks (window_ticks),
    .dup          (ring_dup),
    .head         (ring_head)
  );

  // Result register: load on finish, drop on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      duplicate    <= ring_dup;
      fingerprint  <= hash;
      slot_written <= ring_dup ? 4'd0 : 4'(ring_head);
    end
  end

`ifndef SYNTHESIS
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_finish_loads_result: assert property (@(posedge clk) disable iff (rst)
    fin_fire |=> out_valid)
    else $error("finish item did not produce a result");

  a_dup_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && duplicate) |-> (slot_written == 4'd0))
    else $error("duplicate result carries a nonzero slot");

  a_stall_blocks_finish: assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && (in_q.func == FUNC_FINISH) && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while a finish item is blocked");
`endif

endmodule

/* design/fdrf_hash.sv */
// Running FNV-1a hash with per-section byte limits.
// Depends on fdrf_pkg.
module fdrf_hash (
  input  logic                  clk,
  input  logic                  rst,
  input  fdrf_pkg::hash_ctl_t   ctl,
  output logic [63:0]           hash
);
  import fdrf_pkg::*;

  logic [63:0] running_hash, running_hash_next;
  logic [2:0]  cur_section, cur_section_next;
  logic [7:0]  section_count, section_count_next;
  logic        section_closed, section_closed_next;

  logic        is_sub, is_byte, new_sec, eff_closed;
  logic [63:0] base_hash;
  logic [7:0]  eff_count, cnt_inc, limit;

  always_comb begin
    is_sub     = (ctl.func == FUNC_SUBMITTER);
    is_byte    = (ctl.func <= FUNC_ARGUMENT);
    new_sec    = is_sub || (ctl.func != cur_section);
    base_hash  = is_sub ? FNV_BASIS : running_hash;
    eff_count  = new_sec ? 8'd0 : section_count;
    eff_closed = new_sec ? 1'b0 : section_closed;
    limit      = (ctl.func <= FUNC_TYPE) ? 8'd1 : SECTION_MAX_BYTES;
    cnt_inc    = eff_count + 8'd1;

    running_hash_next   = running_hash;
    cur_section_next    = cur_section;
    section_count_next  = section_count;
    section_closed_next = section_closed;

    if (ctl.fire && is_byte) begin
      cur_section_next = ctl.func;
      if (!eff_closed) begin
        running_hash_next   = fnv_step(base_hash, ctl.data_byte);
        section_count_next  = cnt_inc;
        section_closed_next = (cnt_inc >= limit) ||
                              ((ctl.func >= FUNC_COMMAND) && (ctl.data_byte == 8'd0));
      end else begin
        running_hash_next   = base_hash;
        section_count_next  = eff_count;
        section_closed_next = 1'b1;
      end
    end else if (ctl.fire && (ctl.func == FUNC_FINISH)) begin
      running_hash_next   = FNV_BASIS;
      cur_section_next    = NO_SECTION;
      section_count_next  = 8'd0;
      section_closed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash   <= FNV_BASIS;
      cur_section    <= NO_SECTION;
      section_count  <= 8'd0;
      section_closed <= 1'b0;
    end else begin
      running_hash   <= running_hash_next;
      cur_section    <= cur_section_next;
      section_count  <= section_count_next;
      section_closed <= section_closed_next;
    end
  end

  assign hash = running_hash;

endmodule

/* design/fdrf_ring.sv */
// Ring of recent fingerprints and stamps with a parallel window compare.
// Depends on fdrf_pkg for the default ring depth; parameter from the top level.
module fdrf_ring #(
  parameter int RING_ENTRIES = fdrf_pkg::RING_ENTRIES_DEF,
  localparam int HEAD_W = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rec_fire,
  input  logic [63:0]       fp,
  input  logic [63:0]       now_ticks,
  input  logic [63:0]       window_ticks,
  output logic              dup,
  output logic [HEAD_W-1:0] head
);
  import fdrf_pkg::*;

  logic [63:0]             prints [RING_ENTRIES];
  logic [63:0]             stamps [RING_ENTRIES];
  logic [RING_ENTRIES-1:0] valid;
  logic [RING_ENTRIES-1:0] match;
  logic [HEAD_W-1:0]       ring_head, ring_head_next;

  // Entry never written reads as empty through its valid bit.
  always_comb begin
    for (int i = 0; i < RING_ENTRIES; i++) begin
      match[i] = valid[i] && (stamps[i] != 64'd0) && (prints[i] == fp) &&
                 ((now_ticks - stamps[i]) < window_ticks);
    end
    dup = |match;
    ring_head_next = (ring_head == HEAD_W'(RING_ENTRIES - 1)) ? '0 : ring_head + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rec_fire && !dup) begin
      prints[ring_head] <= fp;
      stamps[ring_head] <= now_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      ring_head <= '0;
    end else if (rec_fire && !dup) begin
      valid[ring_head] <= 1'b1;
      ring_head        <= ring_head_next;
    end
  end

  assign head = ring_head;

endmodule
